// ===== hdl/qpd_pkg.sv =====
// quoted-printable decoder package: run store sizing, escape phase codes,
// character constants and the command/status bundles between controller and datapath
// no dependencies
package qpd_pkg;

    // pending whitespace run store
    localparam int SPACE_RUN_DEPTH = 32;
    localparam int RUN_AW          = $clog2(SPACE_RUN_DEPTH);
    localparam int CNT_W           = $clog2(SPACE_RUN_DEPTH + 1);

    // escape phase codes
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    // characters
    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_HT  = 8'h09;

    // controller to datapath
    typedef struct packed {
        logic latch;       // capture the accepted input
        logic push;        // hold a whitespace byte or flag overflow
        logic rd_start;    // start releasing the held run at entry zero
        logic rd_next;     // step to the next held entry
        logic feed;        // pass one byte through the escape logic
        logic feed_run;    // feed byte comes from the run store
        logic clr_count;   // empty the held run
        logic emit_eq;     // emit a literal '='
        logic emit_first;  // emit the stored escape character, close escape
        logic esc_drop;    // close a lone '=' (soft break)
        logic emit_cr;
        logic emit_lf;
        logic emit_nul;
        logic clr_line;    // clear per-line state
        logic flush;       // send the held result out as the item's last
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       term;       // captured byte is LF or NUL
        logic       blank;      // captured byte is whitespace
        logic       last;       // captured byte ends the input
        logic       count_zero; // no whitespace held
        logic       rd_last;    // current run entry is the final one
        logic [1:0] phase;      // escape phase
        logic       hold_vld;   // a result waits in the hold stage
        logic       can_emit;   // a new result can be taken this cycle
    } t_sts;

endpackage

// ===== hdl/quoted_printable_decoder.sv =====
// quoted-printable decoder top level: stream ports, controller and datapath
// depends on qpd_pkg, qpd_ctrl and qpd_datapath
//
// Takes one encoded byte per input transfer, one item at a time, and gives the decoded
// bytes with inserted CR LF and a final NUL; tlast marks the last result of each item.
// Controller sequence: a whitespace byte is classified and held in the run store; any other
// content byte is classified and fed through the escape logic after each whitespace byte
// released from the run store (one store read and one escape step each), then the line end
// if it ends the input; a line terminator, or a whitespace byte that ends the input, goes to
// its line end. Stalls on the output side lengthen each emitting step; one result is held
// back per item so its last flag is known, and goes out when the item completes.
module quoted_printable_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] in_byte
    input  logic       i_s_axis_tlast,  // end_of_input
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] out_byte
    output logic       o_m_axis_tlast,  // last_result
    output logic [0:0] o_m_axis_tuser   // [0] space_dropped
);
    import qpd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing
    qpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage, escape logic and output stages
    qpd_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_byte  (i_s_axis_tdata),
        .i_in_last  (i_s_axis_tlast),
        .i_m_tready (i_m_axis_tready),
        .o_sts      (sts),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_byte   (o_m_axis_tdata),
        .o_m_last   (o_m_axis_tlast),
        .o_m_drop   (o_m_axis_tuser[0])
    );

endmodule

// ===== hdl/qpd_ctrl.sv =====
// quoted-printable decoder controller: sequences classification, run release,
// escape feed, line end and result flush; uses qpd_pkg
module qpd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  qpd_pkg::t_sts i_sts,
    output qpd_pkg::t_cmd o_cmd
);
    import qpd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLASS = 4'd1;
    localparam logic [3:0] S_RREAD = 4'd2;
    localparam logic [3:0] S_RFEED = 4'd3;
    localparam logic [3:0] S_FEEDC = 4'd4;
    localparam logic [3:0] S_EQ    = 4'd5;
    localparam logic [3:0] S_CH    = 4'd6;
    localparam logic [3:0] S_CR    = 4'd7;
    localparam logic [3:0] S_LF    = 4'd8;
    localparam logic [3:0] S_NUL   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_sts.term) begin
                    n_state = S_EQ;
                end else if (i_sts.blank) begin
                    o_cmd.push = 1'b1;
                    n_state    = i_sts.last ? S_EQ : S_IDLE;
                end else if (i_sts.count_zero) begin
                    n_state = S_FEEDC;
                end else begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = S_RREAD;
                end
            end
            S_RREAD: begin
                n_state = S_RFEED;
            end
            S_RFEED: begin
                if (i_sts.can_emit) begin
                    o_cmd.feed     = 1'b1;
                    o_cmd.feed_run = 1'b1;
                    o_cmd.rd_next  = 1'b1;
                    n_state        = i_sts.rd_last ? S_FEEDC : S_RREAD;
                end
            end
            S_FEEDC: begin
                if (i_sts.can_emit) begin
                    o_cmd.feed      = 1'b1;
                    o_cmd.clr_count = 1'b1;
                    n_state         = i_sts.last ? S_EQ : S_DONE;
                end
            end
            S_EQ: begin
                if (i_sts.can_emit) begin
                    o_cmd.clr_count = 1'b1;
                    if (i_sts.phase == PH_TWO) begin
                        o_cmd.emit_eq = 1'b1;
                        n_state       = S_CH;
                    end else if (i_sts.phase == PH_ONE) begin
                        o_cmd.esc_drop = 1'b1;
                        n_state        = S_NUL;
                    end else begin
                        o_cmd.emit_cr = 1'b1;
                        n_state       = S_LF;
                    end
                end
            end
            S_CH: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit_first = 1'b1;
                    n_state          = S_CR;
                end
            end
            S_CR: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit_cr = 1'b1;
                    n_state       = S_LF;
                end
            end
            S_LF: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit_lf = 1'b1;
                    n_state       = S_NUL;
                end
            end
            S_NUL: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit_nul = i_sts.last;
                    o_cmd.clr_line = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.hold_vld) begin
                    n_state = S_IDLE;
                end else if (i_sts.can_emit) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a transfer in is always followed by classification
    a_accept_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_CLASS))
        else $error("accepted byte not classified");

    // nothing new is taken while a result of the last item still waits in the hold stage
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.hold_vld)
        else $error("hold stage busy in idle");

    // run release only starts with whitespace held
    a_release_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_start |-> !i_sts.count_zero)
        else $error("release of an empty run");

endmodule

// ===== hdl/qpd_datapath.sv =====
// quoted-printable decoder datapath: input capture, whitespace run store,
// escape logic, hold stage and output register; uses qpd_pkg
module qpd_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qpd_pkg::t_cmd i_cmd,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    input  logic          i_m_tready,
    output qpd_pkg::t_sts o_sts,
    output logic          o_m_tvalid,
    output logic [7:0]    o_m_byte,
    output logic          o_m_last,
    output logic          o_m_drop
);
    import qpd_pkg::*;

    // hex digit value, bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    logic [7:0]       r_c;
    logic             r_last;
    logic [7:0]       r_run [SPACE_RUN_DEPTH];
    logic [7:0]       r_rdata;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_ovf;
    logic [1:0]       r_phase;
    logic [7:0]       r_first;
    logic             r_hold_vld;
    logic [7:0]       r_hold_byte;
    logic             r_hold_drop;
    logic             r_out_vld;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_drop;

    logic [7:0] feed_b;
    logic [4:0] h1;
    logic [4:0] h2;
    logic [7:0] hexv;
    logic       n_emit;
    logic [7:0] n_emit_byte;
    logic [1:0] n_phase;
    logic [7:0] n_first;
    logic       load_out;

    // escape logic for one fed byte, and the line end emissions
    always_comb begin
        feed_b      = i_cmd.feed_run ? r_rdata : r_c;
        h1          = hex_digit(r_first);
        h2          = hex_digit(feed_b);
        hexv        = '0;
        if (h1[4]) begin
            hexv = h2[4] ? {h1[3:0], h2[3:0]} : {4'd0, h1[3:0]};
        end
        n_emit      = 1'b0;
        n_emit_byte = feed_b;
        n_phase     = r_phase;
        n_first     = r_first;
        if (i_cmd.feed) begin
            case (r_phase)
                PH_ONE: begin
                    n_first = feed_b;
                    n_phase = PH_TWO;
                end
                PH_TWO: begin
                    n_emit      = 1'b1;
                    n_emit_byte = hexv;
                    n_phase     = PH_NONE;
                end
                default: begin
                    if (feed_b == CH_EQ) begin
                        n_phase = PH_ONE;
                    end else begin
                        n_emit = 1'b1;
                    end
                end
            endcase
        end else if (i_cmd.emit_eq) begin
            n_emit      = 1'b1;
            n_emit_byte = CH_EQ;
        end else if (i_cmd.emit_first) begin
            n_emit      = 1'b1;
            n_emit_byte = r_first;
            n_phase     = PH_NONE;
        end else if (i_cmd.esc_drop) begin
            n_phase = PH_NONE;
        end else if (i_cmd.emit_cr) begin
            n_emit      = 1'b1;
            n_emit_byte = CH_CR;
        end else if (i_cmd.emit_lf) begin
            n_emit      = 1'b1;
            n_emit_byte = CH_LF;
        end else if (i_cmd.emit_nul) begin
            n_emit      = 1'b1;
            n_emit_byte = CH_NUL;
        end
        if (i_cmd.clr_line) begin
            n_first = '0;
        end
        load_out = (n_emit && r_hold_vld) || i_cmd.flush;
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_c    <= i_in_byte;
            r_last <= i_in_last;
        end
    end

    // whitespace run store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_count < CNT_W'(SPACE_RUN_DEPTH))) begin
            r_run[r_count[RUN_AW-1:0]] <= r_c;
        end
        r_rdata <= r_run[r_rd_idx[RUN_AW-1:0]];
    end

    // run count, release index, overflow flag and escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_idx <= '0;
            r_ovf    <= 1'b0;
            r_phase  <= PH_NONE;
            r_first  <= '0;
        end else begin
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (i_cmd.push && (r_count < CNT_W'(SPACE_RUN_DEPTH))) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.rd_start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (i_cmd.clr_line) begin
                r_ovf <= 1'b0;
            end else if (i_cmd.push && (r_count >= CNT_W'(SPACE_RUN_DEPTH))) begin
                r_ovf <= 1'b1;
            end
            r_phase <= n_phase;
            r_first <= n_first;
        end
    end

    // hold stage: a result waits here until the next one shows it was not the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
        end else if (n_emit) begin
            r_hold_vld <= 1'b1;
        end else if (i_cmd.flush) begin
            r_hold_vld <= 1'b0;
        end
        if (n_emit) begin
            r_hold_byte <= n_emit_byte;
            r_hold_drop <= r_ovf;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
        if (load_out) begin
            r_out_byte <= r_hold_byte;
            r_out_drop <= r_hold_drop;
            r_out_last <= i_cmd.flush;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.term       = (r_c == CH_LF) || (r_c == CH_NUL);
        o_sts.blank      = (r_c == CH_SP) || ((r_c >= CH_HT) && (r_c <= CH_CR));
        o_sts.last       = r_last;
        o_sts.count_zero = (r_count == '0);
        o_sts.rd_last    = ((r_rd_idx + 1'b1) == r_count);
        o_sts.phase      = r_phase;
        o_sts.hold_vld   = r_hold_vld;
        o_sts.can_emit   = !r_hold_vld || !r_out_vld || i_m_tready;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_byte   = r_out_byte;
    assign o_m_last   = r_out_last;
    assign o_m_drop   = r_out_drop;

    // run count stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SPACE_RUN_DEPTH))
        else $error("run count beyond store depth");

    // moving the hold stage out never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_vld || i_m_tready))
        else $error("output result overwritten");

    // a flush empties the hold stage and marks the result as last
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (!r_hold_vld && r_out_vld && r_out_last))
        else $error("flush did not deliver a last result");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the quoted-printable decoder: stream stimulus, result checking
// depends on qpd_pkg and quoted_printable_decoder
module testbench;

    import qpd_pkg::*;

    // whitespace codes not named in the package
    localparam logic [7:0] WS_VT = 8'h0B;
    localparam logic [7:0] WS_FF = 8'h0C;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT     = 5000;
    localparam int END_CYCLES     = 60;
    localparam int MAX_REPORTS    = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       dropped;
    } dec_result_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;   // [7:0] in_byte
    logic       i_s_axis_tlast;   // end_of_input
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;   // [7:0] out_byte
    logic       o_m_axis_tlast;   // last_result
    logic [0:0] o_m_axis_tuser;   // [0] space_dropped

    quoted_printable_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // decoder state as predicted
    logic [1:0]  esc_phase;
    logic [7:0]  esc_first;
    logic [7:0]  ws_run [SPACE_RUN_DEPTH];
    int          ws_count;
    logic        ws_overflow;

    dec_result_t item_bytes [$];
    dec_result_t decoded_q [$];

    int  items_sent;
    int  eoi_items;
    int  bytes_checked;
    int  dropped_seen;
    int  mismatches;
    int  burst_left;
    bit  hold_request;
    string hex_digits = "0123456789abcdefABCDEF";

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit is_ws(logic [7:0] c);
        return c == CH_SP || (c >= CH_HT && c <= CH_CR);
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        item_bytes.push_back('{data: b, last: 1'b0, dropped: ws_overflow});
    endfunction

    // one byte through the escape logic
    function automatic void escape_step(logic [7:0] c);
        int h1;
        int h2;
        logic [7:0] v;
        if (esc_phase == PH_ONE) begin
            esc_first = c;
            esc_phase = PH_TWO;
        end else if (esc_phase == PH_TWO) begin
            h1 = hex_digit(esc_first);
            h2 = hex_digit(c);
            v  = 8'd0;
            if (h1 >= 0) begin
                v = 8'(h1);
                if (h2 >= 0) v = 8'(h1 * 16 + h2);
            end
            put_byte(v);
            esc_phase = PH_NONE;
        end else if (c == CH_EQ) begin
            esc_phase = PH_ONE;
        end else begin
            put_byte(c);
        end
    endfunction

    // expected decoded bytes for one accepted input transfer
    function automatic void decode_item(logic [7:0] c, logic eoi);
        dec_result_t r;
        bit term;
        term = (c == CH_LF || c == CH_NUL);
        item_bytes.delete();
        if (!term) begin
            if (is_ws(c)) begin
                if (ws_count < SPACE_RUN_DEPTH) begin
                    ws_run[ws_count] = c;
                    ws_count++;
                end else begin
                    ws_overflow = 1'b1;
                end
            end else begin
                for (int k = 0; k < ws_count; k++) escape_step(ws_run[k]);
                ws_count = 0;
                escape_step(c);
            end
        end
        // line end: open escape goes out literally, lone '=' is a soft break
        if (term || eoi) begin
            ws_count = 0;
            if (esc_phase == PH_TWO) begin
                put_byte(CH_EQ);
                put_byte(esc_first);
                esc_phase = PH_NONE;
            end
            if (esc_phase == PH_ONE) begin
                esc_phase = PH_NONE;
            end else begin
                put_byte(CH_CR);
                put_byte(CH_LF);
            end
            esc_first = 8'd0;
            if (eoi) put_byte(CH_NUL);
            ws_overflow = 1'b0;
        end
        if (item_bytes.size() > 0) begin
            r = item_bytes[item_bytes.size() - 1];
            r.last = 1'b1;
            item_bytes[item_bytes.size() - 1] = r;
        end
        foreach (item_bytes[i]) decoded_q.push_back(item_bytes[i]);
    endfunction

    // one input transfer; the sender may idle between bursts of random length
    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eoi;
        do @(posedge i_clk); while (!o_s_axis_tready);
        decode_item(b, eoi);
        items_sent++;
        if (eoi) eoi_items++;
    endtask

    task automatic send_text(input string s, input bit eoi);
        for (int i = 0; i < s.len(); i++) send_item(s[i], eoi && i == s.len() - 1);
    endtask

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 5))
            0, 1:    return CH_SP;
            2:       return CH_HT;
            3:       return WS_VT;
            4:       return WS_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(8'h80, 8'hFF));
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    function automatic logic [7:0] hex_char();
        return hex_digits[$urandom_range(0, hex_digits.len() - 1)];
    endfunction

    // a line of text, escapes and whitespace, with a random kind of line end
    task automatic send_random_line();
        int n;
        int r;
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                send_item(text_char(), 1'b0);
            end else if (r < 70) begin
                send_item(ws_char(), 1'b0);
            end else if (r < 90) begin
                send_item(CH_EQ, 1'b0);
                send_item(hex_char(), 1'b0);
                send_item(($urandom_range(0, 4) == 0) ? text_char() : hex_char(), 1'b0);
            end else begin
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        // trailing whitespace and soft breaks
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) send_item(ws_char(), 1'b0);
        if ($urandom_range(0, 3) == 0) send_item(CH_EQ, 1'b0);
        if ($urandom_range(0, 7) == 0) send_item(text_char(), 1'b0);
        r = $urandom_range(0, 9);
        if (r < 7)       send_item(CH_LF, 1'b0);
        else if (r == 7) send_item(CH_NUL, 1'b0);
        else if (r == 8) send_item(8'($urandom_range(0, 255)), 1'b1);
        else             send_item(CH_LF, 1'b1);
    endtask

    task automatic test_escapes_and_line_ends();
        send_text("=41=4g=zz\n", 1'b0);
        send_text("=\n", 1'b0);
        send_text("\n", 1'b0);
        send_text("=A\n", 1'b0);
        send_text("= \n", 1'b0);
        send_text("= x\t\n", 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_NUL, 1'b0);
        send_text("=", 1'b1);
        send_text("z", 1'b1);
    endtask

    // whitespace runs around the store depth, released or stripped
    task automatic test_whitespace_overflow();
        int lens [4];
        lens = '{SPACE_RUN_DEPTH, SPACE_RUN_DEPTH + 1,
                 $urandom_range(SPACE_RUN_DEPTH - 4, SPACE_RUN_DEPTH + 8),
                 $urandom_range(SPACE_RUN_DEPTH - 4, SPACE_RUN_DEPTH + 8)};
        foreach (lens[i]) begin
            if (i == 3) send_item(CH_EQ, 1'b0);
            repeat (lens[i]) send_item(ws_char(), 1'b0);
            if (i != 1) send_item(text_char(), 1'b0);
            send_item(hex_char(), 1'b0);
            send_item(CH_LF, i == 2);
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_receiver_hold();
        int start;
        start = items_sent;
        hold_request = 1'b1;
        while (items_sent < start + 40) send_random_line();
    endtask

    task automatic test_random_text(input int target);
        while (items_sent < target) send_random_line();
    endtask

    // receiver stall patterns, plus the long hold on request
    initial begin : rx_stall
        int mode;
        int left;
        int phase;
        bit hold_taken;
        mode       = 0;
        left       = 150;
        phase      = 0;
        hold_taken = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(50, 300);
                end
                left--;
                phase++;
                case (mode)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2:       i_m_axis_tready <= ($urandom_range(0, 6) != 0);
                    default: i_m_axis_tready <= (phase % 5 < 2);
                endcase
            end
        end
    end

    // result checking against the oldest expectation
    always @(posedge i_clk) begin
        dec_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected result data=%02h last=%b dropped=%b", $time,
                             o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser[0]);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                bytes_checked++;
                if (o_m_axis_tuser[0]) dropped_seen++;
                if (o_m_axis_tdata !== want.data || o_m_axis_tlast !== want.last ||
                    o_m_axis_tuser[0] !== want.dropped) begin
                    if (mismatches < MAX_REPORTS)
                        $display({"%0t: expected data=%02h last=%b dropped=%b, ",
                                  "got data=%02h last=%b dropped=%b"},
                                 $time, want.data, want.last, want.dropped,
                                 o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        int idle;
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle = 0;
        end else begin
            idle++;
            if (idle == IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                         IDLE_LIMIT, decoded_q.size());
                $display("** quoted_printable_decoder: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tlast  = 1'b0;
        hold_request    = 1'b0;
        esc_phase       = PH_NONE;
        esc_first       = 8'd0;
        ws_count        = 0;
        ws_overflow     = 1'b0;
        items_sent      = 0;
        eoi_items       = 0;
        bytes_checked   = 0;
        dropped_seen    = 0;
        mismatches      = 0;
        burst_left      = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_escapes_and_line_ends();
        test_whitespace_overflow();
        test_receiver_hold();
        test_random_text(370);

        // drain, then let any stray result show up
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("covered %0d input transfers (%0d ending the input), %0d decoded bytes checked,",
                 items_sent, eoi_items, bytes_checked);
        $display("%0d of them flagged for dropped whitespace, %0d mismatches",
                 dropped_seen, mismatches);
        if (mismatches == 0)
            $display("** quoted_printable_decoder: PASSED **");
        else
            $display("** quoted_printable_decoder: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/qpd_pkg.sv
hdl/qpd_ctrl.sv
hdl/qpd_datapath.sv
hdl/quoted_printable_decoder.sv
test/testbench.sv
